[rtl/keb_pkg.sv]
// shared types and constants of the k-mer edge list builder
`default_nettype none
package keb_pkg;

  localparam int ALPHABET_SIZE_DEF = 6;
  localparam logic [5:0] KMER_ORDER_RST = 6'd31;
  localparam logic [3:0] DOLLAR_CODE = 4'd3;

  localparam logic [1:0] ACT_DUMMY_ADD   = 2'd0;
  localparam logic [1:0] ACT_DUMMY_CLOSE = 2'd1;
  localparam logic [1:0] ACT_SUFFIX_ROW  = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] clipped_lcp;
    logic [2:0] bwt_symbol;
    logic       dollar_row;
    logic       window_dollar_free;
    logic       final_row;
  } in_item_t;

  typedef struct packed {
    logic [3:0] edge_code;
    logic       edge_valid;
    logic       node_last;
    logic       node_solid;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/kmer_edge_list_builder_top.sv]
// k-mer edge list builder: collects node symbols and emits coded edges
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+--------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_item_t suffix row
//  out     | output    | out_valid_o/out_stall_i | out_item_t coded edge
//  cfg     | input     | cfg_valid_i/cfg_ready_o | kmer_order (6 bits)
//
// a row that closes no node leaves the input free; a closing row or dummy
// close stalls the input for its result words, at most ALPHABET_SIZE - 1, one
// per cycle from the shared lowest-symbol picker unless the output stalls
// reset loads kmer_order 31 and the symbol set {1}; no clearing pass
// a stalled output word holds the picker; input stays stalled until the last
// word of the node is in the output register
`default_nettype none
module kmer_edge_list_builder_top #(
  parameter int ALPHABET_SIZE = keb_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire keb_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output keb_pkg::out_item_t      out_item_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [5:0]         cfg_data_i
);
  import keb_pkg::*;

  localparam int SetW = ALPHABET_SIZE;
  localparam int SymW = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MODE_EDGES,
    MODE_DOLLAR,
    MODE_NO_EDGE
  } mode_e;

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  logic [SetW-1:0] sym_set_q, sym_set_d;
  logic [SetW-1:0] flag_set_q, flag_set_d;
  logic            done_q, done_d;
  logic [5:0]      order_q, order_d;
  logic [SetW-1:0] emit_set_q, emit_set_d;
  logic [SetW-1:0] emit_flag_q, emit_flag_d;
  logic            emit_solid_q, emit_solid_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic            in_acc;
  logic            out_free;
  logic            load;
  logic [SetW-1:0] sym_bit;
  logic [SetW-1:0] edge_bits;
  logic            close;
  logic [SymW-1:0] pick;
  logic [SetW-1:0] remain;

  // lowest symbol above zero in the pending set
  function automatic logic [SymW-1:0] low_pick(logic [SetW-1:0] s);
    logic [SymW-1:0] r;
    r = '0;
    for (int j = SetW - 1; j >= 1; j--) begin
      if (s[j]) r = SymW'(j);
    end
    return r;
  endfunction

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign load        = (state_q == ST_EMIT) && out_free;

  assign sym_bit   = (32'(in_item_i.bwt_symbol) < ALPHABET_SIZE)
                     ? (SetW'(1) << in_item_i.bwt_symbol) : '0;
  assign edge_bits = sym_set_q & ~SetW'(1);
  assign close     = (in_item_i.final_row || (in_item_i.clipped_lcp < order_q))
                     && (sym_set_q != '0);
  assign pick      = low_pick(emit_set_q);
  assign remain    = emit_set_q & ~(SetW'(1) << pick);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    sym_set_d    = sym_set_q;
    flag_set_d   = flag_set_q;
    done_d       = done_q;
    order_d      = order_q;
    emit_set_d   = emit_set_q;
    emit_flag_d  = emit_flag_q;
    emit_solid_d = emit_solid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    if (cfg_valid_i) order_d = cfg_data_i;

    if (in_acc && !done_q) begin
      unique case (in_item_i.action)
        ACT_DUMMY_ADD: begin
          sym_set_d = sym_set_q | sym_bit;
        end
        ACT_DUMMY_CLOSE: begin
          emit_set_d   = edge_bits;
          emit_flag_d  = '0;
          emit_solid_d = 1'b0;
          mode_d       = (edge_bits != '0) ? MODE_EDGES : MODE_NO_EDGE;
          state_d      = ST_EMIT;
          sym_set_d    = '0;
        end
        ACT_SUFFIX_ROW: begin
          if (close) begin
            emit_set_d   = edge_bits;
            emit_flag_d  = flag_set_q;
            emit_solid_d = in_item_i.window_dollar_free;
            state_d      = ST_EMIT;
            priority if (in_item_i.dollar_row) mode_d = MODE_DOLLAR;
            else if (edge_bits != '0)          mode_d = MODE_EDGES;
            else                               mode_d = MODE_NO_EDGE;
            if (in_item_i.final_row) begin
              done_d = 1'b1;
            end else begin
              if ((order_q != 6'd0) && (in_item_i.clipped_lcp == order_q - 6'd1)) begin
                flag_set_d = flag_set_q | sym_set_q;
              end else begin
                flag_set_d = '0;
              end
              sym_set_d = sym_bit;
            end
          end else if (in_item_i.final_row) begin
            done_d = 1'b1;
          end else begin
            sym_set_d = sym_set_q | sym_bit;
          end
        end
        default: ;
      endcase
    end

    if (load) begin
      out_valid_d         = 1'b1;
      out_d.node_solid    = emit_solid_q;
      out_d.node_last     = 1'b1;
      unique case (mode_q)
        MODE_DOLLAR: begin
          out_d.edge_code  = DOLLAR_CODE;
          out_d.edge_valid = 1'b1;
          state_d          = ST_IDLE;
        end
        MODE_NO_EDGE: begin
          out_d.edge_code  = 4'd0;
          out_d.edge_valid = 1'b0;
          state_d          = ST_IDLE;
        end
        default: begin
          out_d.edge_code  = {3'(pick), emit_flag_q[pick]};
          out_d.edge_valid = 1'b1;
          out_d.node_last  = (remain == '0);
          emit_set_d       = remain;
          if (remain == '0) state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= MODE_EDGES;
      sym_set_q    <= SetW'(2);
      flag_set_q   <= '0;
      done_q       <= 1'b0;
      order_q      <= KMER_ORDER_RST;
      emit_set_q   <= '0;
      emit_flag_q  <= '0;
      emit_solid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      sym_set_q    <= sym_set_d;
      flag_set_q   <= flag_set_d;
      done_q       <= done_d;
      order_q      <= order_d;
      emit_set_q   <= emit_set_d;
      emit_flag_q  <= emit_flag_d;
      emit_solid_q <= emit_solid_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  // an edge word never carries symbol zero
  a_edge_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.edge_valid |-> out_q.edge_code[3:1] != 3'd0)
    else $error("edge word with symbol zero");

  // a word without an edge always ends its node
  a_no_edge_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.edge_valid |-> out_q.node_last)
    else $error("edgeless word not last");

  // the end of the stream is sticky
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("stream end cleared");

  // edge mode never runs with an empty pending set
  a_edges_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && (mode_q == MODE_EDGES) |-> emit_set_q != '0)
    else $error("edge emission with nothing pending");

  // a word that does not end the node keeps the picker busy
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !out_d.node_last |=> state_q == ST_EMIT)
    else $error("node left before its last edge");

endmodule
`default_nettype wire

[test/kmer_edge_list_builder_top_test.sv]
// self-checking testbench of the k-mer edge list builder with its own edge predictor
`timescale 1ns / 1ps
module kmer_edge_list_builder_top_test;
  import keb_pkg::*;

  localparam int ALPHA = ALPHABET_SIZE_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int PRINT_CAP = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [5:0] cfg_data_i = '0;

  // predictor state
  logic [5:0] kmer_order_m = KMER_ORDER_RST;
  logic [5:0] node_syms = 6'b000010;
  logic [5:0] flagged_syms = '0;
  logic       stream_ended = 1'b0;
  out_item_t  edge_q[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int err_count = 0;

  kmer_edge_list_builder_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  function automatic void queue_edge(logic [3:0] code, logic vld, logic last, logic solid);
    out_item_t e;
    e.edge_code = code;
    e.edge_valid = vld;
    e.node_last = last;
    e.node_solid = solid;
    edge_q.push_back(e);
  endfunction

  // edges in ascending symbol order, symbol 0 never goes out
  function automatic void queue_node(logic [5:0] syms, logic [5:0] flags, logic solid);
    int top;
    top = 0;
    for (int j = 1; j < ALPHA; j++) if (syms[j]) top = j;
    if (top == 0) begin
      queue_edge(4'd0, 1'b0, 1'b1, solid);
    end else begin
      for (int j = 1; j <= top; j++) begin
        if (syms[j]) queue_edge({3'(j), flags[j]}, 1'b1, j == top, solid);
      end
    end
  endfunction

  function automatic void predict_edges(in_item_t w);
    logic [5:0] sym_bit;
    if (stream_ended) return;
    sym_bit = (w.bwt_symbol < ALPHA) ? 6'd1 << w.bwt_symbol : 6'd0;
    case (w.action)
      ACT_DUMMY_ADD: begin
        node_syms = node_syms | sym_bit;
      end
      ACT_DUMMY_CLOSE: begin
        queue_node(node_syms, 6'd0, 1'b0);
        node_syms = '0;
      end
      ACT_SUFFIX_ROW: begin
        if ((w.final_row || w.clipped_lcp < kmer_order_m) && node_syms != 0) begin
          if (w.dollar_row) queue_edge(DOLLAR_CODE, 1'b1, 1'b1, w.window_dollar_free);
          else queue_node(node_syms, flagged_syms, w.window_dollar_free);
          if (w.final_row) begin
            stream_ended = 1'b1;
            return;
          end
          if (kmer_order_m != 0 && w.clipped_lcp == kmer_order_m - 6'd1) begin
            flagged_syms = flagged_syms | node_syms;
          end else begin
            flagged_syms = '0;
          end
          node_syms = '0;
        end else if (w.final_row) begin
          stream_ended = 1'b1;
          return;
        end
        node_syms = node_syms | sym_bit;
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t row(int lcp, int sym, bit dollar, bit solid);
    in_item_t w;
    w.action = ACT_SUFFIX_ROW;
    w.clipped_lcp = 6'(lcp);
    w.bwt_symbol = 3'(sym);
    w.dollar_row = dollar;
    w.window_dollar_free = solid;
    w.final_row = 1'b0;
    return w;
  endfunction

  function automatic in_item_t dummy(logic [1:0] act, int sym);
    in_item_t w;
    logic [31:0] r;
    r = $urandom;
    w = r[$bits(in_item_t)-1:0];
    w.action = act;
    w.bwt_symbol = 3'(sym);
    w.final_row = 1'b0;
    return w;
  endfunction

  // mostly rows with LCPs around the order, a little dummy and unused noise
  function automatic in_item_t rand_word();
    in_item_t w;
    int pick;
    w = row(0, 0, $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
    w.bwt_symbol = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
    pick = $urandom_range(0, 9);
    if (kmer_order_m == 0 || pick >= 8) w.clipped_lcp = 6'($urandom_range(0, 63));
    else if (pick < 3) w.clipped_lcp = kmer_order_m - 6'd1;
    else if (pick < 5) w.clipped_lcp = 6'($urandom_range(0, kmer_order_m - 1));
    else w.clipped_lcp = 6'($urandom_range(kmer_order_m, 63));
    pick = $urandom_range(0, 19);
    if (pick == 0) w.action = ACT_DUMMY_ADD;
    else if (pick == 1) w.action = ACT_DUMMY_CLOSE;
    else if (pick == 2) w.action = ACT_UNUSED;
    return w;
  endfunction

  // called at a rising edge; returns at the edge that took the word
  task automatic send_word(input in_item_t w);
    int gap;
    logic took;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= w;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    predict_edges(w);
  endtask

  // stop sending and let every expected edge drain
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (edge_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_order(input logic [5:0] v);
    logic took;
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid_i <= 1'b0;
    kmer_order_m = v;
  endtask

  task automatic test_dummy_node();
    send_word(dummy(ACT_DUMMY_ADD, 0));
    send_word(dummy(ACT_DUMMY_ADD, 3));
    send_word(dummy(ACT_DUMMY_ADD, 7));
    send_word(dummy(ACT_DUMMY_ADD, 5));
    send_word(dummy(ACT_DUMMY_CLOSE, 0));
    // nothing left in the set: one invalid word
    send_word(dummy(ACT_DUMMY_CLOSE, 2));
    send_word(dummy(ACT_UNUSED, 4));
  endtask

  task automatic test_row_closes();
    send_word(row(0, 0, 0, 1));
    send_word(row(12, 6, 0, 1));
    send_word(row(63, 2, 0, 0));
    send_word(row(31, 4, 0, 1));
    send_word(row(30, 1, 0, 0));
    send_word(row(63, 2, 0, 1));
    send_word(row(3, 3, 1, 1));
    send_word(row(20, 0, 1, 0));
  endtask

  task automatic test_flag_marks();
    send_word(row(63, 1, 0, 0));
    send_word(row(40, 2, 0, 0));
    send_word(row(50, 4, 0, 1));
    send_word(row(31, 5, 0, 0));
    send_word(row(30, 1, 0, 1));
    send_word(row(63, 3, 0, 0));
    send_word(row(63, 5, 0, 0));
    send_word(row(0, 2, 0, 1));
  endtask

  task automatic test_order_extremes();
    write_order(6'd1);
    send_word(row(0, 4, 0, 1));
    send_word(row(1, 2, 0, 0));
    send_word(row(0, 5, 0, 1));
    write_order(6'd63);
    send_word(row(63, 1, 0, 0));
    send_word(row(62, 3, 0, 1));
    write_order(6'd0);
    send_word(row(0, 2, 0, 1));
    send_word(row(0, 0, 1, 0));
  endtask

  // receiver holds off while words keep coming, so the block backs up
  task automatic test_output_hold();
    write_order(6'd20);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (14) send_word(rand_word());
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 30;
    stall_pct = 30;
    repeat (10) send_word(rand_word());
    settle();
    repeat (10) send_word(rand_word());
  endtask

  task automatic run_random(input int n, input logic [5:0] order, input int s_pct,
                            input int r_pct);
    write_order(order);
    send_idle_pct = s_pct;
    stall_pct = r_pct;
    repeat (n) send_word(rand_word());
  endtask

  task automatic test_random_phases();
    run_random(20, 6'd31, 0, 0);
    run_random(20, 6'd1, 72, 0);
    run_random(20, 6'd63, 0, 72);
    run_random(20, 6'($urandom_range(2, 62)), 30, 30);
  endtask

  // final row closes the last node; later words are all ignored
  task automatic test_stream_end();
    write_order(6'd31);
    send_idle_pct = 0;
    stall_pct = 30;
    send_word(row(63, 4, 0, 0));
    send_word(row(40, 3, 0, 0));
    send_word('{action: ACT_SUFFIX_ROW, clipped_lcp: 6'd63, bwt_symbol: 3'd2,
                dollar_row: 1'b0, window_dollar_free: 1'b1, final_row: 1'b1});
    send_word(dummy(ACT_DUMMY_CLOSE, 1));
    send_word(row(0, 1, 0, 1));
    send_word(rand_word());
    settle();
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // output word is taken at the next rising edge
  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (edge_q.size() == 0) begin
        report_mismatch($sformatf("unexpected edge word %h", out_item_o));
      end else begin
        want = edge_q.pop_front();
        if (out_item_o.edge_code !== want.edge_code ||
            out_item_o.edge_valid !== want.edge_valid ||
            out_item_o.node_last !== want.node_last ||
            out_item_o.node_solid !== want.node_solid) begin
          report_mismatch($sformatf(
            "edge word code %0d valid %b last %b solid %b, expected %0d %b %b %b",
            out_item_o.edge_code, out_item_o.edge_valid, out_item_o.node_last,
            out_item_o.node_solid, want.edge_code, want.edge_valid, want.node_last,
            want.node_solid));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_dummy_node();
    test_row_closes();
    test_flag_marks();
    test_order_extremes();
    test_output_hold();
    test_drain_pause();
    test_random_phases();
    test_stream_end();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && edge_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
